FILE: sv/rlcg_pkg.sv
// Package for the ranged LCG burst generator: shared constants, codes and types.
// Has no dependencies; every other file of the block imports it.
package rlcg_pkg;

   localparam int VALUE_W    = 32;
   localparam int BURST_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 2 * VALUE_W;

   localparam logic [VALUE_W-1:0] LCG_MUL     = 32'd2891336453;
   localparam logic [VALUE_W-1:0] LCG_ADD     = 32'd1500450271;
   localparam logic [VALUE_W-1:0] STATE_RESET = 32'd2076571060;
   localparam logic [VALUE_W-1:0] STATE_MASK  = 32'h7FFF_FFFF;

   // Command codes carried by the request channel.
   localparam logic CMD_GENERATE = 1'b0;
   localparam logic CMD_SEED     = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_COUNT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_TO_INT = 2'd3;

   // Range settings after ordering, as seen by the sequencer.
   typedef struct packed {
      logic signed [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0]        span;
      logic                      round;
   } rlcg_cfg_type;

endpackage

FILE: sv/rlcg_req_if.sv
// Request channel of the ranged LCG burst generator: valid/ready plus command payload.
// Depends on rlcg_pkg.
interface rlcg_req_if;
   import rlcg_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic [VALUE_W-1:0] seed_value;

   modport source (output valid, output command, output seed_value, input ready);
   modport sink (input valid, input command, input seed_value, output ready);
endinterface

FILE: sv/rlcg_rsp_if.sv
// Result channel of the ranged LCG burst generator: valid/ready plus value payload.
// Depends on rlcg_pkg.
interface rlcg_rsp_if;
   import rlcg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] random_value;
   logic                      last_of_burst;

   modport source (output valid, output random_value, output last_of_burst, input ready);
   modport sink (input valid, input random_value, input last_of_burst, output ready);
endinterface

FILE: sv/rlcg_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// Depends on rlcg_pkg.
module rlcg_mul (
   input  logic                         clock,
   input  logic [rlcg_pkg::VALUE_W-1:0] op_a,
   input  logic [rlcg_pkg::VALUE_W-1:0] op_b,
   output logic [rlcg_pkg::PROD_W-1:0]  prod
);
   import rlcg_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

FILE: sv/rlcg_seq.sv
// Sequencer of the ranged LCG burst generator: holds the generator state, steps the
// shared multiplier through the LCG and scaling products and drives the result register.
// Depends on rlcg_pkg, rlcg_req_if and rlcg_rsp_if.
module rlcg_seq #(
   parameter int CNT_W = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rlcg_pkg::rlcg_cfg_type       cfg,
   input  logic [CNT_W-1:0]             burst_len,
   rlcg_req_if.sink                     req,
   rlcg_rsp_if.source                   rsp,
   output logic [rlcg_pkg::VALUE_W-1:0] mul_a,
   output logic [rlcg_pkg::VALUE_W-1:0] mul_b,
   input  logic [rlcg_pkg::PROD_W-1:0]  mul_prod
);
   import rlcg_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LCG,
      S_ADV,
      S_SCL,
      S_FIN,
      S_WAIT
   } state_type;

   state_type                 state_ff;
   logic [VALUE_W-1:0]        gen_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   logic [VALUE_W-1:0]        gen_in;
   logic [VALUE_W-1:0]        sum;
   logic [VALUE_W-1:0]        value_in;

   // The multiplier always takes the generator state; only the second operand changes.
   always_comb begin
      mul_a = gen_ff;
      mul_b = (state_ff == S_SCL) ? cfg.span : LCG_MUL;
   end

   always_comb begin
      gen_in = (mul_prod[VALUE_W-1:0] + LCG_ADD) & STATE_MASK;
      sum    = cfg.lo + mul_prod[PROD_W-2:VALUE_W-1];
      // With round set, truncation toward zero: a negative value with a fraction moves up one whole step.
      if (!cfg.round) begin
         value_in = sum;
      end else if (!sum[VALUE_W-1] || (sum[15:0] == 16'd0)) begin
         value_in = {sum[VALUE_W-1:16], 16'd0};
      end else begin
         value_in = {sum[VALUE_W-1:16] + 16'd1, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= STATE_RESET;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  if (req.command == CMD_SEED) begin
                     gen_ff <= req.seed_value;
                  end else begin
                     rem_ff   <= burst_len;
                     state_ff <= S_LCG;
                  end
               end
            end
            S_LCG: begin
               state_ff <= S_ADV;
            end
            S_ADV: begin
               gen_ff   <= gen_in;
               state_ff <= S_SCL;
            end
            S_SCL: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               rsp_value_ff <= value_in;
               rsp_last_ff  <= (rem_ff == CNT_W'(1));
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  rem_ff       <= rem_ff - CNT_W'(1);
                  state_ff     <= rsp_last_ff ? S_IDLE : S_LCG;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.random_value  = rsp_value_ff;
   assign rsp.last_of_burst = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_req_while_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request accepted while a result is pending");

   a_generate_starts : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.command == CMD_GENERATE)) |=> !req.ready)
      else $error("generate command did not start a burst");

   a_last_ends_burst : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_of_burst) |=> req.ready)
      else $error("block not idle after the last transfer of a burst");

   a_state_masked : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCL) |-> !gen_ff[VALUE_W-1])
      else $error("generator state not masked to 31 bits before scaling");

   a_round_whole : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && cfg.round) |-> (rsp.random_value[15:0] == 16'd0))
      else $error("rounded value carries fraction bits");
`endif

endmodule

FILE: sv/ranged_lcg_burst_generator_top.sv
// Ranged LCG burst generator. A seed transfer loads the generator state and yields nothing.
// A generate transfer yields burst_count values (one for zero, MAX_BURST above it); each
// is built in S_LCG, S_ADV, S_SCL and S_FIN, after acceptance or the previous transfer,
// as the one shared multiplier is used twice per value (LCG step, then range scaling).
// The next request is accepted the cycle after the last value's transfer.
// Synchronous reset restores the CSR registers, generator state and sequencer and clears all valids.
module ranged_lcg_burst_generator_top #(
   parameter int MAX_BURST = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rlcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlcg_pkg::CSR_DATA_W-1:0] csr_wdata,
   rlcg_req_if.sink                        req,
   rlcg_rsp_if.source                      rsp
);
   import rlcg_pkg::*;

   localparam int CNT_W = $clog2(MAX_BURST + 1);

   logic signed [VALUE_W-1:0] range_low_ff;
   logic signed [VALUE_W-1:0] range_high_ff;
   logic [BURST_W-1:0]        burst_count_ff;
   logic                      round_ff;

   rlcg_cfg_type              cfg_ff;
   rlcg_cfg_type              cfg_in;
   logic [CNT_W-1:0]          burst_len_in;

   logic [VALUE_W-1:0]        mul_a;
   logic [VALUE_W-1:0]        mul_b;
   logic [PROD_W-1:0]         mul_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= '0;
         range_high_ff  <= 32'sd65536;
         burst_count_ff <= BURST_W'(1);
         round_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_LOW:    range_low_ff   <= csr_wdata;
            CSR_RANGE_HIGH:   range_high_ff  <= csr_wdata;
            CSR_BURST_COUNT:  burst_count_ff <= csr_wdata[BURST_W-1:0];
            CSR_ROUND_TO_INT: round_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The range is put in order and registered, as it is first needed only in the scaling
   // step of a burst. The burst length is loaded at the request transfer, so it stays direct.
   always_comb begin
      if (range_low_ff > range_high_ff) begin
         cfg_in.lo   = range_high_ff;
         cfg_in.span = range_low_ff - range_high_ff;
      end else begin
         cfg_in.lo   = range_low_ff;
         cfg_in.span = range_high_ff - range_low_ff;
      end
      cfg_in.round = round_ff;

      if (burst_count_ff == '0) begin
         burst_len_in = CNT_W'(1);
      end else if (int'(burst_count_ff) > MAX_BURST) begin
         burst_len_in = CNT_W'(MAX_BURST);
      end else begin
         burst_len_in = CNT_W'(burst_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   rlcg_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   rlcg_seq #(
      .CNT_W (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .burst_len (burst_len_in),
      .req       (req),
      .rsp       (rsp),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_prod  (mul_prod)
   );

endmodule
